// ===== rtl/core/subtitle_atlas_shelf_packer_defines.svh =====
`ifndef SUBTITLE_ATLAS_SHELF_PACKER_DEFINES_SVH
`define SUBTITLE_ATLAS_SHELF_PACKER_DEFINES_SVH

// Immediate-style check sampled on every clock edge outside reset.
`define SASP_ASSERT_NOW(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that holds in the cycle after the antecedent.
`define SASP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/sasp_pkg.sv =====
`timescale 1ns / 1ps

package sasp_pkg;

  // pixel_format codes
  localparam logic [1:0] FMT_INDEXED = 2'd0;
  localparam logic [1:0] FMT_RGBA    = 2'd1;
  localparam logic [1:0] FMT_GLYPH   = 2'd2;
  localparam logic [1:0] FMT_NONE    = 2'd3;

  // register index (byte address bit 2)
  localparam logic [0:0] REG_PIXEL_FORMAT = 1'b0;
  localparam logic [0:0] REG_MAX_TEX_W    = 1'b1;

  localparam logic [1:0]  FMT_RESET   = FMT_INDEXED;
  localparam logic [14:0] MTW_RESET   = 15'd4096;

  // destination row alignment in bytes (power of two)
  localparam int unsigned ROW_ALIGN   = 4;
  localparam int unsigned ALIGN_BITS  = $clog2(ROW_ALIGN);
  localparam logic [18:0] ALIGN_ADD   = 19'(ROW_ALIGN - 1);
  localparam logic [17:0] MAX18       = 18'h3ffff;
  localparam logic [17:0] ALIGN_TOP   = 18'(32'h3ffff - (32'h3ffff % ROW_ALIGN));
  localparam logic [15:0] MAX16       = 16'hffff;
  localparam logic [31:0] MAX32       = 32'hffffffff;
  localparam int unsigned PIX_SHIFT   = 2;
  localparam logic [31:0] COLOR_KEEP  = 32'hffffff00;
  localparam logic [7:0]  ALPHA_FULL  = 8'hff;

  typedef struct packed {
    logic [1:0]  pixel_format;
    logic [14:0] max_texture_width;
  } cfg_t;

  // per-part values handed from the stride stage to the placement stage
  typedef struct packed {
    logic [17:0] row_bytes;
    logic [17:0] row_pixels;
    logic [31:0] area;
    logic [13:0] height;
    logic [31:0] glyph;
    logic        first;
    logic        last;
  } prep_t;

endpackage

// ===== rtl/core/sasp_cfg.sv =====
`timescale 1ns / 1ps

module sasp_cfg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  output sasp_pkg::cfg_t cfg
);
  import sasp_pkg::*;

  logic [1:0]  fmt_r;
  logic [14:0] mtw_r;
  logic [0:0]  reg_idx;
  logic        wr_en;

  assign reg_idx = paddr[2:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_RESET;
      mtw_r <= MTW_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PIXEL_FORMAT: fmt_r <= pwdata[1:0];
        REG_MAX_TEX_W:    mtw_r <= pwdata[14:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PIXEL_FORMAT: prdata = {30'd0, fmt_r};
      REG_MAX_TEX_W:    prdata = {17'd0, mtw_r};
      default:          prdata = '0;
    endcase
  end

  assign cfg.pixel_format      = fmt_r;
  assign cfg.max_texture_width = mtw_r;

endmodule

// ===== rtl/core/sasp_prep.sv =====
`timescale 1ns / 1ps

// Input register, then stride alignment, area multiply and glyph color into a
// second register. Unknown-format parts are dropped here.
module sasp_prep (
  input  logic            clk,
  input  logic            rst_n,
  input  sasp_pkg::cfg_t  cfg,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [13:0]     in_part_height,
  input  logic [15:0]     in_source_stride,
  input  logic [31:0]     in_part_color,
  input  logic            in_first_part,
  input  logic            in_last_part,
  output logic            s2_valid,
  output sasp_pkg::prep_t s2_data,
  input  logic            place_ready
);
  import sasp_pkg::*;

  logic        s1_valid_r;
  logic [13:0] s1_height_r;
  logic [15:0] s1_stride_r;
  logic [31:0] s1_color_r;
  logic        s1_first_r;
  logic        s1_last_r;
  logic        s2_valid_r;
  prep_t       s2_r;
  prep_t       s2_nxt;
  logic        en1;
  logic        en2;
  logic [17:0] bytes_raw;
  logic [18:0] bytes_up;
  logic [18:0] bytes_al;

  assign en2      = !s2_valid_r || place_ready;
  assign en1      = !s1_valid_r || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en1) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      s1_height_r <= in_part_height;
      s1_stride_r <= in_source_stride;
      s1_color_r  <= in_part_color;
      s1_first_r  <= in_first_part;
      s1_last_r   <= in_last_part;
    end
  end

  always_comb begin
    case (cfg.pixel_format)
      FMT_INDEXED: bytes_raw = {s1_stride_r, 2'b00};
      default:     bytes_raw = {2'b00, s1_stride_r};
    endcase
    bytes_up = {1'b0, bytes_raw} + ALIGN_ADD;
    bytes_al = (bytes_up >> ALIGN_BITS) << ALIGN_BITS;

    s2_nxt.row_bytes = bytes_al[18] ? ALIGN_TOP : bytes_al[17:0];
    s2_nxt.row_pixels = (cfg.pixel_format == FMT_GLYPH) ? s2_nxt.row_bytes
                                                        : (s2_nxt.row_bytes >> PIX_SHIFT);
    // 18 x 14 bit product always fits in 32 bits
    s2_nxt.area   = {14'd0, s2_nxt.row_bytes} * {18'd0, s1_height_r};
    s2_nxt.height = s1_height_r;
    s2_nxt.glyph  = (cfg.pixel_format == FMT_GLYPH)
                  ? ((s1_color_r & COLOR_KEEP) | {24'd0, ALPHA_FULL - s1_color_r[7:0]})
                  : '0;
    s2_nxt.first  = s1_first_r;
    s2_nxt.last   = s1_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en2) begin
      s2_valid_r <= s1_valid_r && (cfg.pixel_format != FMT_NONE);
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && s1_valid_r) begin
      s2_r <= s2_nxt;
    end
  end

  assign s2_valid = s2_valid_r;
  assign s2_data  = s2_r;

endmodule

// ===== rtl/core/sasp_place.sv =====
`timescale 1ns / 1ps
`include "subtitle_atlas_shelf_packer_defines.svh"

// Shelf placement, running offset and sheet extent, result register.
module sasp_place (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [14:0]     max_texture_width,
  input  logic            s2_valid,
  input  sasp_pkg::prep_t s2_data,
  output logic            place_ready,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [17:0]     out_row_bytes,
  output logic [17:0]     out_row_pixels,
  output logic [31:0]     out_buffer_offset,
  output logic [17:0]     out_atlas_x,
  output logic [15:0]     out_atlas_y,
  output logic [31:0]     out_glyph_color,
  output logic [17:0]     out_sheet_width,
  output logic [15:0]     out_sheet_height,
  output logic [17:0]     out_widest_row,
  output logic [13:0]     out_tallest_part,
  output logic            out_frame_done
);
  import sasp_pkg::*;

  logic [17:0] cursor_x_r, cursor_x_nxt;
  logic [15:0] cursor_y_r, cursor_y_nxt;
  logic [13:0] shelf_h_r, shelf_h_nxt;
  logic [31:0] offset_r, offset_nxt;
  logic [17:0] frame_w_r, frame_w_nxt;
  logic [17:0] widest_r, widest_nxt;
  logic [13:0] tallest_r, tallest_nxt;

  logic        out_valid_r;
  logic [17:0] row_bytes_r, row_pixels_r, atlas_x_r, sheet_w_r, widest_out_r;
  logic [31:0] offset_out_r, glyph_r;
  logic [15:0] atlas_y_r, sheet_h_r, sheet_h_nxt;
  logic [13:0] tallest_out_r;
  logic        done_r;

  logic [17:0] cx0, cx_w;
  logic [15:0] cy0, cy_w;
  logic [13:0] sh0, sh_w;
  logic [31:0] off0;
  logic [17:0] fw0;
  logic [32:0] off_sum;
  logic [18:0] x_end, cx_sum;
  logic [16:0] y_sum, top_sum;
  logic        wrap;
  logic        take;

  assign place_ready = !out_valid_r || !out_stall;
  assign take        = place_ready && s2_valid;

  always_comb begin
    // a first part restarts the frame before it is placed
    cx0  = s2_data.first ? '0 : cursor_x_r;
    cy0  = s2_data.first ? '0 : cursor_y_r;
    sh0  = s2_data.first ? '0 : shelf_h_r;
    off0 = s2_data.first ? '0 : offset_r;
    fw0  = s2_data.first ? '0 : frame_w_r;

    off_sum    = {1'b0, off0} + {1'b0, s2_data.area};
    offset_nxt = off_sum[32] ? MAX32 : off_sum[31:0];

    widest_nxt  = (s2_data.row_pixels > widest_r) ? s2_data.row_pixels : widest_r;
    tallest_nxt = (s2_data.height > tallest_r) ? s2_data.height : tallest_r;

    x_end = {1'b0, cx0} + {1'b0, s2_data.row_pixels};
    wrap  = x_end > {4'd0, max_texture_width};
    y_sum = {1'b0, cy0} + {3'd0, sh0};

    cx_w = wrap ? '0 : cx0;
    cy_w = wrap ? (y_sum[16] ? MAX16 : y_sum[15:0]) : cy0;
    sh_w = wrap ? '0 : sh0;

    shelf_h_nxt  = (s2_data.height > sh_w) ? s2_data.height : sh_w;
    cx_sum       = {1'b0, cx_w} + {1'b0, s2_data.row_pixels};
    cursor_x_nxt = cx_sum[18] ? MAX18 : cx_sum[17:0];
    cursor_y_nxt = cy_w;
    frame_w_nxt  = (cursor_x_nxt > fw0) ? cursor_x_nxt : fw0;
    top_sum      = {1'b0, cy_w} + {3'd0, shelf_h_nxt};
    sheet_h_nxt  = top_sum[16] ? MAX16 : top_sum[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r  <= '0;
      cursor_y_r  <= '0;
      shelf_h_r   <= '0;
      offset_r    <= '0;
      frame_w_r   <= '0;
      widest_r    <= '0;
      tallest_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (place_ready) begin
        out_valid_r <= s2_valid;
      end
      if (take) begin
        cursor_x_r <= cursor_x_nxt;
        cursor_y_r <= cursor_y_nxt;
        shelf_h_r  <= shelf_h_nxt;
        offset_r   <= offset_nxt;
        frame_w_r  <= frame_w_nxt;
        widest_r   <= widest_nxt;
        tallest_r  <= tallest_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      row_bytes_r   <= s2_data.row_bytes;
      row_pixels_r  <= s2_data.row_pixels;
      offset_out_r  <= off0;
      atlas_x_r     <= cx_w;
      atlas_y_r     <= cy_w;
      glyph_r       <= s2_data.glyph;
      sheet_w_r     <= frame_w_nxt;
      sheet_h_r     <= sheet_h_nxt;
      widest_out_r  <= widest_nxt;
      tallest_out_r <= tallest_nxt;
      done_r        <= s2_data.last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_row_bytes     = row_bytes_r;
  assign out_row_pixels    = row_pixels_r;
  assign out_buffer_offset = offset_out_r;
  assign out_atlas_x       = atlas_x_r;
  assign out_atlas_y       = atlas_y_r;
  assign out_glyph_color   = glyph_r;
  assign out_sheet_width   = sheet_w_r;
  assign out_sheet_height  = sheet_h_r;
  assign out_widest_row    = widest_out_r;
  assign out_tallest_part  = tallest_out_r;
  assign out_frame_done    = done_r;

  `SASP_ASSERT_NOW(a_stride_aligned, !out_valid_r || (row_bytes_r[1:0] == 2'b00), "row stride not aligned")
  `SASP_ASSERT_NOW(a_corner_in_sheet, !out_valid_r || (atlas_y_r <= sheet_h_r && atlas_x_r <= sheet_w_r), "part corner outside sheet")
  `SASP_ASSERT_NOW(a_widest_covers, !out_valid_r || (row_pixels_r <= widest_out_r), "widest row below current stride")
  `SASP_ASSERT_NEXT(a_first_at_origin, take && s2_data.first, (atlas_x_r == '0) && (atlas_y_r == '0), "first part not at origin")

endmodule

// ===== rtl/core/subtitle_atlas_shelf_packer.sv =====
`timescale 1ns / 1ps
// Channel  | handshake                     | contents
// ---------+-------------------------------+--------------------------------------------
// in_      | in_valid / in_stall           | part width, height, stride, color, frame marks
// out_     | out_valid / out_stall         | strides, offset, atlas corner, sheet size, maxima
// cfg      | psel/penable/pwrite, pready=1 | pixel_format @0x0, max_texture_width @0x4
//
// One part per cycle while out_stall is low; a part's result passes the input register
// (loaded at the transfer), then the stride/multiply and placement/result registers.
// The per-part chain is the placement stage: cursor add, width compare, saturating adds.
// Synchronous active-low reset clears the frame cursor, offset, sheet and the maxima.
// Each stage advances when the stage after it is empty or moving, so bubbles fill while
// out_stall is high; in_stall rises only once all three registers are occupied.
// Parts sent while pixel_format is 3 are dropped and change nothing.

module subtitle_atlas_shelf_packer (
  input  logic        clk,
  input  logic        rst_n,
  // part input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [13:0] in_part_width,
  input  logic [13:0] in_part_height,
  input  logic [15:0] in_source_stride,
  input  logic [31:0] in_part_color,
  input  logic        in_first_part,
  input  logic        in_last_part,
  // placement result
  output logic        out_valid,
  input  logic        out_stall,
  output logic [17:0] out_row_bytes,
  output logic [17:0] out_row_pixels,
  output logic [31:0] out_buffer_offset,
  output logic [17:0] out_atlas_x,
  output logic [15:0] out_atlas_y,
  output logic [31:0] out_glyph_color,
  output logic [17:0] out_sheet_width,
  output logic [15:0] out_sheet_height,
  output logic [17:0] out_widest_row,
  output logic [13:0] out_tallest_part,
  output logic        out_frame_done,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sasp_pkg::*;

  cfg_t  cfg;
  logic  s2_valid;
  prep_t s2_data;
  logic  place_ready;

  // Register file: format and shelf width limit, to be written by the user only while the block is idle; unenforced.
  sasp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Stride alignment, row_bytes * height product and glyph color. The part width is
  // carried by the interface but no result depends on it; packing uses the stride.
  sasp_prep u_prep (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_part_height   (in_part_height),
    .in_source_stride (in_source_stride),
    .in_part_color    (in_part_color),
    .in_first_part    (in_first_part),
    .in_last_part     (in_last_part),
    .s2_valid         (s2_valid),
    .s2_data          (s2_data),
    .place_ready      (place_ready)
  );

  // Shelf cursor, packed-buffer offset, sheet extent and maxima; result register.
  sasp_place u_place (
    .clk               (clk),
    .rst_n             (rst_n),
    .max_texture_width (cfg.max_texture_width),
    .s2_valid          (s2_valid),
    .s2_data           (s2_data),
    .place_ready       (place_ready),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_row_bytes     (out_row_bytes),
    .out_row_pixels    (out_row_pixels),
    .out_buffer_offset (out_buffer_offset),
    .out_atlas_x       (out_atlas_x),
    .out_atlas_y       (out_atlas_y),
    .out_glyph_color   (out_glyph_color),
    .out_sheet_width   (out_sheet_width),
    .out_sheet_height  (out_sheet_height),
    .out_widest_row    (out_widest_row),
    .out_tallest_part  (out_tallest_part),
    .out_frame_done    (out_frame_done)
  );

endmodule
